// File: src/rtrp_pkg.sv
`default_nettype none

package rtrp_pkg;

    // pixel_format codes
    localparam logic [2:0] FMT_MONO   = 3'd0;
    localparam logic [2:0] FMT_NIBBLE = 3'd1;
    localparam logic [2:0] FMT_GRAY   = 3'd2;
    localparam logic [2:0] FMT_RGB16  = 3'd3;
    localparam logic [2:0] FMT_RGB24  = 3'd4;
    localparam logic [2:0] FMT_RGB32  = 3'd5;
    localparam logic [2:0] FMT_RGBA32 = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd0;
    localparam logic [2:0] REG_MSB_FIRST      = 3'd1;
    localparam logic [2:0] REG_RED_POSITION   = 3'd2;
    localparam logic [2:0] REG_GREEN_POSITION = 3'd3;
    localparam logic [2:0] REG_BLUE_POSITION  = 3'd4;
    localparam logic [2:0] REG_ALPHA_POSITION = 3'd5;
    localparam logic [2:0] REG_CHANNEL_MASKS  = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef struct packed {
        logic [2:0]  pixel_format;
        logic        msb_first;
        logic [3:0]  red_position;
        logic [3:0]  green_position;
        logic [3:0]  blue_position;
        logic [1:0]  alpha_position;
        logic [47:0] channel_masks;
    } cfg_t;

    // bytes produced by one pixel, byte 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            row_last;
    } pack_t;

endpackage

`default_nettype wire

// File: src/rgba_to_raster_packer_unit.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    tdata = pixel_red, pixel_green, pixel_blue,
//                                             pixel_alpha; tlast = row_last
// m_        out        m_tvalid / m_tready    tdata = out_byte; tlast = run_last;
//                                             tuser = row_end
// cfg_      in         cfg_valid / cfg_ready  cfg_index = register, cfg_data = value
//
// A pixel is packed in the cycle it is accepted and lands in a pixel buffer; the
// byte-wide output register then drains it one byte per cycle unless m_tready
// stalls it. A pixel yields at most one byte (1-bit, 4-bit, gray), two bytes (16-bit)
// or three to four bytes (24/32-bit). Sub-byte pixels that complete no byte emit
// nothing. The next pixel is taken in the cycle the buffer's last byte moves to
// the output register. Reset (aresetn low, synchronous) empties both stages and
// loads the register defaults; cfg writes are always taken.

module rgba_to_raster_packer_unit
    import rtrp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_byte
    output logic                       m_tlast,
    output logic                       m_tuser,   // [0] row_end
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    pack_t res;
    logic  acc_clear;
    logic  room;
    logic  accept;
    logic  load;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;
    assign load     = accept && (res.count != 3'd0);

    rtrp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .acc_clear (acc_clear)
    );

    rtrp_pack u_pack (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .acc_clear   (acc_clear),
        .accept      (accept),
        .pixel_red   (s_tdata[7:0]),
        .pixel_green (s_tdata[15:8]),
        .pixel_blue  (s_tdata[23:16]),
        .pixel_alpha (s_tdata[31:24]),
        .row_last    (s_tlast),
        .res         (res)
    );

    rtrp_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: src/rtrp_cfg.sv
`default_nettype none

module rtrp_cfg
    import rtrp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg,
    output logic                       acc_clear
);

    cfg_t cfg_reg;
    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    // a format or bit-order change drops any partially packed byte
    assign acc_clear = wr && ((cfg_index == REG_PIXEL_FORMAT) || (cfg_index == REG_MSB_FIRST));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format   <= FMT_GRAY;
            cfg_reg.msb_first      <= 1'b0;
            cfg_reg.red_position   <= 4'd0;
            cfg_reg.green_position <= 4'd1;
            cfg_reg.blue_position  <= 4'd2;
            cfg_reg.alpha_position <= 2'd3;
            cfg_reg.channel_masks  <= '0;
        end else if (wr) begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT:   cfg_reg.pixel_format   <= cfg_data[2:0];
                REG_MSB_FIRST:      cfg_reg.msb_first      <= cfg_data[0];
                REG_RED_POSITION:   cfg_reg.red_position   <= cfg_data[3:0];
                REG_GREEN_POSITION: cfg_reg.green_position <= cfg_data[3:0];
                REG_BLUE_POSITION:  cfg_reg.blue_position  <= cfg_data[3:0];
                REG_ALPHA_POSITION: cfg_reg.alpha_position <= cfg_data[1:0];
                REG_CHANNEL_MASKS:  cfg_reg.channel_masks  <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/rtrp_pack.sv
`default_nettype none

module rtrp_pack
    import rtrp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       acc_clear,
    input  wire logic       accept,
    input  wire logic [7:0] pixel_red,
    input  wire logic [7:0] pixel_green,
    input  wire logic [7:0] pixel_blue,
    input  wire logic [7:0] pixel_alpha,
    input  wire logic       row_last,
    output pack_t           res
);

    logic [7:0]  acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  cnt_inc;
    logic [2:0]  bit_sh;
    logic [7:0]  acc_or_mono;
    logic [7:0]  acc_or_nib;
    logic        nib_high;
    logic [15:0] gray_sum;
    logic [7:0]  gray;
    logic [15:0] w16;
    logic [3:0][7:0] chan_bytes;

    assign gray_sum = 16'd77 * {8'd0, pixel_red} + 16'd151 * {8'd0, pixel_green}
                    + 16'd28 * {8'd0, pixel_blue};
    assign gray     = gray_sum[15:8];

    assign cnt_inc     = cnt_reg + 3'd1;
    assign bit_sh      = cfg.msb_first ? (3'd7 - cnt_reg) : cnt_reg;
    assign acc_or_mono = acc_reg | ({7'd0, pixel_green[7]} << bit_sh);
    assign nib_high    = cfg.msb_first ? (cnt_reg == 3'd0) : (cnt_reg != 3'd0);
    assign acc_or_nib  = acc_reg | (nib_high ? {gray[7:4], 4'd0} : {4'd0, gray[7:4]});

    assign w16 = (({pixel_red,   8'd0} >> cfg.red_position)   & cfg.channel_masks[47:32])
               | (({pixel_green, 8'd0} >> cfg.green_position) & cfg.channel_masks[31:16])
               | (({pixel_blue,  8'd0} >> cfg.blue_position)  & cfg.channel_masks[15:0]);

    // later channel wins where positions collide; off-pixel offsets never match
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            chan_bytes[k] = 8'd0;
            if (cfg.red_position == 4'(k))   chan_bytes[k] = pixel_red;
            if (cfg.green_position == 4'(k)) chan_bytes[k] = pixel_green;
            if (cfg.blue_position == 4'(k))  chan_bytes[k] = pixel_blue;
            if ((cfg.pixel_format == FMT_RGBA32) && (cfg.alpha_position == 2'(k)))
                chan_bytes[k] = pixel_alpha;
        end
    end

    always_comb begin
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        res.bytes    = '0;
        res.count    = 3'd0;
        res.row_last = row_last;
        unique case (cfg.pixel_format)
            FMT_MONO: begin
                if ((cnt_inc == 3'd0) || row_last) begin
                    res.bytes[0] = acc_or_mono;
                    res.count    = 3'd1;
                    acc_next     = 8'd0;
                    cnt_next     = 3'd0;
                end else begin
                    acc_next = acc_or_mono;
                    cnt_next = cnt_inc;
                end
            end
            FMT_NIBBLE: begin
                if ((cnt_inc >= 3'd2) || row_last) begin
                    res.bytes[0] = acc_or_nib;
                    res.count    = 3'd1;
                    acc_next     = 8'd0;
                    cnt_next     = 3'd0;
                end else begin
                    acc_next = acc_or_nib;
                    cnt_next = cnt_inc;
                end
            end
            FMT_GRAY: begin
                res.bytes[0] = gray;
                res.count    = 3'd1;
            end
            FMT_RGB16: begin
                res.bytes[0] = cfg.msb_first ? w16[15:8] : w16[7:0];
                res.bytes[1] = cfg.msb_first ? w16[7:0]  : w16[15:8];
                res.count    = 3'd2;
            end
            FMT_RGB24: begin
                res.bytes[2:0] = chan_bytes[2:0];
                res.count      = 3'd3;
            end
            FMT_RGB32, FMT_RGBA32: begin
                res.bytes = chan_bytes;
                res.count = 3'd4;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 8'd0;
            cnt_reg <= 3'd0;
        end else if (acc_clear) begin
            acc_reg <= 8'd0;
            cnt_reg <= 3'd0;
        end else if (accept) begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: src/rtrp_serial.sv
`default_nettype none

module rtrp_serial
    import rtrp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire pack_t      res,
    output logic            room,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    logic [3:0][7:0] buf_bytes_reg;
    logic [2:0]      buf_count_reg;
    logic [1:0]      buf_idx_reg;
    logic            buf_row_last_reg;
    logic            buf_valid_reg;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       m_tuser_reg;

    logic out_free, move, final_move;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign move       = buf_valid_reg && out_free;
    assign final_move = move && (({1'b0, buf_idx_reg} + 3'd1) == buf_count_reg);

    // the pixel buffer frees up in the cycle its last byte moves out
    assign room = !buf_valid_reg || final_move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            buf_idx_reg   <= 2'd0;
        end else if (load) begin
            buf_valid_reg <= 1'b1;
            buf_idx_reg   <= 2'd0;
        end else if (final_move) begin
            buf_valid_reg <= 1'b0;
        end else if (move) begin
            buf_idx_reg <= buf_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_bytes_reg    <= res.bytes;
            buf_count_reg    <= res.count;
            buf_row_last_reg <= res.row_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (move) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_tdata_reg <= buf_bytes_reg[buf_idx_reg];
            m_tlast_reg <= final_move;
            m_tuser_reg <= final_move && buf_row_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
